// File: sv/ssm_pkg.sv
// types, opcodes and chip tables for the serial save memory slave
`default_nettype none
package ssm_pkg;

   localparam int CW = 20;  // width of capacities and sweep limits

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_ERASE,
      ST_EMIT
   } st_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ADDR = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   localparam logic [7:0] OP_WREN  = 8'h06;
   localparam logic [7:0] OP_WRDI  = 8'h04;
   localparam logic [7:0] OP_RDSR  = 8'h05;
   localparam logic [7:0] OP_WRSR  = 8'h01;
   localparam logic [7:0] OP_READ  = 8'h03;
   localparam logic [7:0] OP_READH = 8'h0B;
   localparam logic [7:0] OP_PROG  = 8'h02;
   localparam logic [7:0] OP_PROGH = 8'h0A;
   localparam logic [7:0] OP_RDID  = 8'h9F;
   localparam logic [7:0] OP_SE4K  = 8'h20;
   localparam logic [7:0] OP_SE64K = 8'hD8;
   localparam logic [7:0] OP_PE    = 8'hDB;
   localparam logic [7:0] OP_CE    = 8'hC7;
   localparam logic [7:0] OP_DPD   = 8'hB9;
   localparam logic [7:0] OP_RDP   = 8'hAB;

   localparam logic [2:0] TYPE_EE512 = 3'd1;
   localparam logic [2:0] TYPE_EE64K = 3'd3;

   localparam logic [15:0] CTRL_MASK = 16'hE043;
   localparam int CTRL_EN   = 15;
   localparam int CTRL_HOLD = 6;

   function automatic logic [CW-1:0] chip_size(input logic [2:0] t);
      logic [CW-1:0] c;
      unique case (t)
         3'd1: c = CW'(512);
         3'd2: c = CW'(8192);
         3'd3: c = CW'(65536);
         3'd4: c = CW'(262144);
         3'd5: c = CW'(524288);
         3'd6: c = CW'(32768);
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [1:0] addr_count(input logic [2:0] t);
      logic [1:0] n;
      unique case (t)
         3'd1: n = 2'd1;
         3'd4, 3'd5: n = 2'd3;
         default: n = 2'd2;
      endcase
      return n;
   endfunction

   function automatic logic [23:0] chip_id(input logic [2:0] t);
      logic [23:0] id;
      unique case (t)
         3'd1: id = 24'hFF0000;
         3'd2: id = 24'hFF0001;
         3'd3: id = 24'hFF0002;
         3'd4: id = 24'h204012;
         3'd5: id = 24'h204013;
         3'd6: id = 24'h040401;
         default: id = 24'hFFFFFF;
      endcase
      return id;
   endfunction

endpackage
`default_nettype wire

// File: sv/spi_save_memory_slave.sv
// serial save memory slave: control word, spi phase machine and byte store
// control writes and plain exchanges respond directly, reads after one store read,
//   erases after sweeping the erased bytes (one byte per cycle through the store write port)
// throughput: one transaction at a time; next accepted once the result is registered
// reset: synchronous; afterwards the store is filled with 0xFF, during which no transaction
//   is accepted (csr writes are taken); MEM_BYTES must be a power of two, not checked here
`default_nettype none
module spi_save_memory_slave #(
   parameter int MEM_BYTES = 524288
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [15:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_read_byte,
   output logic [15:0]      rsp_control_readback,
   output logic             rsp_modified,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_save_type
);
   import ssm_pkg::*;

   localparam int AW = $clog2(MEM_BYTES);

   logic [7:0] mem_array [MEM_BYTES];

   st_type        state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic [2:0]    type_ff;
   logic [15:0]   ctrl_ff, ctrl_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [23:0]   addr_ff, addr_in;
   logic [1:0]    left_ff, left_in;
   logic          latch_ff, latch_in;
   logic [7:0]    prot_ff, prot_in;
   logic [7:0]    last_ff, last_in;
   logic          changed_ff, changed_in;
   logic [AW:0]   sw_ff, sw_in;
   logic [AW:0]   sw_end_ff, sw_end_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic [15:0]   rsp_ctrl_ff, rsp_ctrl_in;
   logic          rsp_mod_ff, rsp_mod_in;
   logic [7:0]    rdata_ff;

   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [7:0]    mem_wd;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] cap;
   logic [CW-1:0] mask;

   always_comb begin
      cap = chip_size(type_ff);
      if (cap > CW'(MEM_BYTES)) begin
         cap = CW'(MEM_BYTES);
      end
      mask = cap - CW'(1);
   end

   assign rd_addr = addr_ff[AW-1:0] & mask[AW-1:0];

   always_comb begin
      logic [7:0]    b;
      logic [23:0]   na;
      logic [1:0]    nl;
      logic [23:0]   base;
      logic [CW-1:0] esize;
      logic [CW-1:0] eend;
      logic          ers;
      logic [23:0]   id;
      state_in     = state_ff;
      phase_in     = phase_ff;
      ctrl_in      = ctrl_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      left_in      = left_ff;
      latch_in     = latch_ff;
      prot_in      = prot_ff;
      last_in      = last_ff;
      changed_in   = changed_ff;
      sw_in        = sw_ff;
      sw_end_in    = sw_end_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_ctrl_in  = rsp_ctrl_ff;
      rsp_mod_in   = rsp_mod_ff;
      mem_we       = 1'b0;
      mem_wa       = sw_ff[AW-1:0];
      mem_wd       = 8'hFF;
      b            = req_value[7:0];
      na           = ((addr_ff << 8) | {16'h0, b});
      nl           = left_ff - 2'd1;
      base         = '0;
      esize        = '0;
      eend         = '0;
      ers          = 1'b0;
      id           = chip_id(type_ff);

      unique case (state_ff)
         ST_CLEAR, ST_ERASE: begin
            mem_we = 1'b1;
            sw_in  = sw_ff + (AW+1)'(1);
            if (sw_in == sw_end_ff) begin
               state_in = (state_ff == ST_CLEAR) ? ST_IDLE : ST_EMIT;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EMIT;
               if (!req_action) begin
                  ctrl_in = req_value & CTRL_MASK;
                  if (ctrl_ff[CTRL_EN] && (!ctrl_in[CTRL_EN] ||
                        (ctrl_ff[CTRL_HOLD] && !ctrl_in[CTRL_HOLD]))) begin
                     phase_in = PH_IDLE;
                     cmd_in   = '0;
                     addr_in  = '0;
                     left_in  = '0;
                  end
               end else if (!ctrl_ff[CTRL_EN] || cap == '0) begin
                  last_in = '0;
               end else begin
                  unique case (phase_ff)
                     PH_ADDR: begin
                        addr_in = na;
                        left_in = nl;
                        last_in = '0;
                        if (nl == 2'd0) begin
                           priority case (cmd_ff)
                              OP_SE4K: begin
                                 ers = 1'b1; base = na & ~24'hFFF;  esize = CW'(4096);
                              end
                              OP_SE64K: begin
                                 ers = 1'b1; base = na & ~24'hFFFF; esize = CW'(65536);
                              end
                              OP_PE: begin
                                 ers = 1'b1; base = na & ~24'hFF;   esize = CW'(256);
                              end
                              default: phase_in = PH_DATA;
                           endcase
                           if (ers) begin
                              latch_in = 1'b0;
                              phase_in = PH_IDLE;
                              if (base < {4'h0, cap}) begin
                                 eend = base[CW-1:0] + esize;
                                 if (eend > cap) begin
                                    eend = cap;
                                 end
                                 sw_in      = base[AW:0];
                                 sw_end_in  = eend[AW:0];
                                 changed_in = 1'b1;
                                 state_in   = ST_ERASE;
                              end
                           end
                        end
                     end
                     PH_DATA: begin
                        priority case (cmd_ff)
                           OP_READ, OP_READH: begin
                              addr_in  = addr_ff + 24'd1;
                              state_in = ST_READ;
                           end
                           OP_PROG, OP_PROGH: begin
                              mem_we     = 1'b1;
                              mem_wa     = rd_addr;
                              mem_wd     = b;
                              changed_in = 1'b1;
                              addr_in    = addr_ff + 24'd1;
                              last_in    = '0;
                           end
                           OP_RDSR: last_in = prot_ff | {6'h0, latch_ff, 1'b0};
                           OP_WRSR: begin
                              prot_in = b & 8'h0C;
                              last_in = '0;
                           end
                           OP_RDID: begin
                              if (addr_ff == 24'd0) begin
                                 last_in = id[15:8];
                              end else if (addr_ff == 24'd1) begin
                                 last_in = id[7:0];
                              end else begin
                                 last_in = '0;
                              end
                              addr_in = addr_ff + 24'd1;
                           end
                           default: last_in = 8'hFF;
                        endcase
                     end
                     default: begin
                        cmd_in  = b;
                        last_in = '0;
                        priority case (b)
                           OP_WREN: latch_in = 1'b1;
                           OP_WRDI: latch_in = 1'b0;
                           OP_RDSR: begin
                              last_in  = prot_ff | {6'h0, latch_ff, 1'b0};
                              phase_in = PH_DATA;
                           end
                           OP_WRSR: phase_in = PH_DATA;
                           OP_READ, OP_READH, OP_PROG, OP_PROGH: begin
                              if (b == OP_READ || b == OP_READH || latch_ff) begin
                                 addr_in = '0;
                                 if (b == OP_PROGH || b == OP_READH) begin
                                    if (type_ff == TYPE_EE512) begin
                                       addr_in = 24'h1;
                                    end else if (type_ff == TYPE_EE64K) begin
                                       addr_in = 24'h10000;
                                    end
                                 end
                                 left_in  = addr_count(type_ff);
                                 phase_in = PH_ADDR;
                              end
                           end
                           OP_RDID: begin
                              addr_in  = '0;
                              last_in  = id[23:16];
                              phase_in = PH_DATA;
                           end
                           OP_SE4K, OP_SE64K, OP_PE: begin
                              if (latch_ff) begin
                                 addr_in  = '0;
                                 left_in  = addr_count(type_ff);
                                 phase_in = PH_ADDR;
                              end
                           end
                           OP_CE: begin
                              if (latch_ff) begin
                                 sw_in      = '0;
                                 sw_end_in  = cap[AW:0];
                                 changed_in = 1'b1;
                                 latch_in   = 1'b0;
                                 state_in   = ST_ERASE;
                              end
                           end
                           OP_DPD, OP_RDP: ;
                           default: last_in = 8'hFF;
                        endcase
                     end
                  endcase
                  // without chip-select hold, chip select is dropped after every byte
                  if (!ctrl_ff[CTRL_HOLD]) begin
                     phase_in = PH_IDLE;
                     cmd_in   = '0;
                     addr_in  = '0;
                     left_in  = '0;
                  end
               end
            end
         end
         ST_READ: begin
            last_in  = rdata_ff;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = last_ff;
               rsp_ctrl_in  = ctrl_ff;
               rsp_mod_in   = changed_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         phase_ff     <= PH_IDLE;
         type_ff      <= '0;
         ctrl_ff      <= '0;
         cmd_ff       <= '0;
         addr_ff      <= '0;
         left_ff      <= '0;
         latch_ff     <= 1'b0;
         prot_ff      <= '0;
         last_ff      <= '0;
         changed_ff   <= 1'b0;
         sw_ff        <= '0;
         sw_end_ff    <= (AW+1)'(MEM_BYTES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         ctrl_ff      <= ctrl_in;
         cmd_ff       <= cmd_in;
         addr_ff      <= addr_in;
         left_ff      <= left_in;
         latch_ff     <= latch_in;
         prot_ff      <= prot_in;
         last_ff      <= last_in;
         changed_ff   <= changed_in;
         sw_ff        <= sw_in;
         sw_end_ff    <= sw_end_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            type_ff <= csr_save_type;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_ctrl_ff <= rsp_ctrl_in;
      rsp_mod_ff  <= rsp_mod_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_array[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem_array[rd_addr];
   end

   assign req_stall            = (state_ff != ST_IDLE);
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_read_byte        = rsp_byte_ff;
   assign rsp_control_readback = rsp_ctrl_ff;
   assign rsp_modified         = rsp_mod_ff;

endmodule
`default_nettype wire

// File: tb/sv/tb_spi_save_memory_slave.sv
// self-checking testbench for the serial save memory slave
`default_nettype none
module tb_spi_save_memory_slave;
   timeunit 1ns;
   timeprecision 1ps;
   import ssm_pkg::*;

   localparam int MEM_SIZE  = 524288;
   localparam int RUN_LIMIT = 20000000;
   localparam int ITEM_GOAL = 650;

   localparam logic [2:0] T_NONE = 3'd0, T_EE8K = 3'd2, T_FL256K = 3'd4;
   localparam logic [2:0] T_FL512K = 3'd5, T_FRAM = 3'd6, T_ALIAS = 3'd7;
   localparam logic [15:0] CTL_HOLD_ON = 16'h8040;  // enable with chip-select hold
   localparam logic [15:0] CTL_RELEASE = 16'h8000;  // enable, hold dropped
   localparam logic [15:0] CTL_OFF     = 16'h0000;

   typedef struct packed {
      logic [7:0]  rb;
      logic [15:0] ctrl;
      logic        md;
   } spi_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = 1'b0;
   logic [15:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_read_byte;
   logic [15:0] rsp_control_readback;
   logic        rsp_modified;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_save_type = '0;

   spi_save_memory_slave dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_action(req_action), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_read_byte(rsp_read_byte), .rsp_control_readback(rsp_control_readback),
      .rsp_modified(rsp_modified),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_save_type(csr_save_type)
   );

   initial forever #10 clock = ~clock;

   // chip model state
   logic [2:0]  m_type;
   logic [15:0] m_ctrl;
   phase_type   m_phase;
   logic [7:0]  m_cmd;
   logic [23:0] m_addr;
   logic [1:0]  m_left;
   logic        m_wel;
   logic [7:0]  m_prot;
   logic [7:0]  m_last;
   logic        m_chg;
   logic [7:0]  m_mem [MEM_SIZE];

   spi_reply_type pending_replies[$];
   int          mismatches = 0;
   int          cycles = 0;
   int          items_sent = 0;
   int          stall_left = 0;

   function automatic int unsigned capacity_of(logic [2:0] t);
      int unsigned c;
      c = (t == 3'd1) ? 512 : (t == 3'd2) ? 8192 : (t == 3'd3) ? 65536 :
          (t == 3'd4) ? 262144 : (t == 3'd5) ? 524288 : (t == 3'd6) ? 32768 : 0;
      return (c > MEM_SIZE) ? MEM_SIZE : c;
   endfunction

   function automatic logic [1:0] addr_bytes_of(logic [2:0] t);
      if (t == 3'd1) return 2'd1;
      if (t == 3'd4 || t == 3'd5) return 2'd3;
      return 2'd2;
   endfunction

   function automatic logic [23:0] jedec_of(logic [2:0] t);
      case (t)
         3'd1, 3'd2, 3'd3: return {16'hFF00, 6'd0, t[1:0] - 2'd1};
         3'd4: return 24'h204012;
         3'd5: return 24'h204013;
         3'd6: return 24'h040401;
         default: return 24'hFFFFFF;
      endcase
   endfunction

   function automatic logic [7:0] status_byte();
      return m_prot | (m_wel ? 8'h02 : 8'h00);
   endfunction

   task automatic end_transfer();
      m_phase = PH_IDLE;
      m_cmd = '0;
      m_addr = '0;
      m_left = '0;
   endtask

   task automatic fill_erased(int unsigned base, int unsigned size);
      int unsigned cap, stop;
      cap = capacity_of(m_type);
      if (base < cap) begin
         stop = (base + size > cap) ? cap : base + size;
         for (int unsigned i = base; i < stop; i++) m_mem[i] = 8'hFF;
         m_chg = 1'b1;
      end
      m_wel = 1'b0;
      m_phase = PH_IDLE;
   endtask

   task automatic begin_address(logic [7:0] b);
      m_addr = '0;
      if (b == OP_PROGH || b == OP_READH) begin
         if (m_type == 3'd1) m_addr = 24'h1;
         else if (m_type == 3'd3) m_addr = 24'h10000;
      end
      m_left = addr_bytes_of(m_type);
      m_phase = PH_ADDR;
   endtask

   task automatic take_opcode(logic [7:0] b);
      logic [23:0] id;
      id = jedec_of(m_type);
      m_cmd = b;
      m_last = '0;
      case (b)
         OP_WREN: m_wel = 1'b1;
         OP_WRDI: m_wel = 1'b0;
         OP_RDSR: begin m_last = status_byte(); m_phase = PH_DATA; end
         OP_WRSR: m_phase = PH_DATA;
         OP_READ, OP_READH: begin_address(b);
         OP_PROG, OP_PROGH: if (m_wel) begin_address(b);
         OP_RDID: begin
            m_addr = '0;
            m_last = id[23:16];
            m_phase = PH_DATA;
         end
         OP_SE4K, OP_SE64K, OP_PE: if (m_wel) begin
            m_addr = '0;
            m_left = addr_bytes_of(m_type);
            m_phase = PH_ADDR;
         end
         OP_CE: if (m_wel) begin
            for (int unsigned i = 0; i < capacity_of(m_type); i++) m_mem[i] = 8'hFF;
            m_chg = 1'b1;
            m_wel = 1'b0;
         end
         OP_DPD, OP_RDP: ;
         default: m_last = 8'hFF;
      endcase
   endtask

   task automatic take_address(logic [7:0] b);
      m_addr = {m_addr[15:0], b};
      m_left = m_left - 2'd1;
      m_last = '0;
      if (m_left == 2'd0) begin
         if (m_cmd == OP_SE4K) fill_erased(m_addr & ~24'hFFF, 4096);
         else if (m_cmd == OP_SE64K) fill_erased(m_addr & ~24'hFFFF, 65536);
         else if (m_cmd == OP_PE) fill_erased(m_addr & ~24'hFF, 256);
         else m_phase = PH_DATA;
      end
   endtask

   task automatic take_data(logic [7:0] b);
      int unsigned cap;
      logic [23:0] id;
      cap = capacity_of(m_type);
      id = jedec_of(m_type);
      case (m_cmd)
         OP_READ, OP_READH: begin
            m_last = m_mem[m_addr % cap];
            m_addr = m_addr + 24'd1;
         end
         OP_PROG, OP_PROGH: begin
            m_mem[m_addr % cap] = b;
            m_chg = 1'b1;
            m_addr = m_addr + 24'd1;
            m_last = '0;
         end
         OP_RDSR: m_last = status_byte();
         OP_WRSR: begin m_prot = b & 8'h0C; m_last = '0; end
         OP_RDID: begin
            m_last = (m_addr == 24'd0) ? id[15:8] : (m_addr == 24'd1) ? id[7:0] : 8'h00;
            m_addr = m_addr + 24'd1;
         end
         default: m_last = 8'hFF;
      endcase
   endtask

   task automatic predict_spi_reply(logic act, logic [15:0] v);
      logic was_en, old_hold;
      if (!act) begin
         was_en = m_ctrl[CTRL_EN];
         old_hold = m_ctrl[CTRL_HOLD];
         m_ctrl = v & CTRL_MASK;
         if (was_en && (!m_ctrl[CTRL_EN] || (old_hold && !m_ctrl[CTRL_HOLD])))
            end_transfer();
      end else if (!m_ctrl[CTRL_EN] || capacity_of(m_type) == 0) begin
         m_last = '0;
      end else begin
         case (m_phase)
            PH_ADDR: take_address(v[7:0]);
            PH_DATA: take_data(v[7:0]);
            default: take_opcode(v[7:0]);
         endcase
         if (!m_ctrl[CTRL_HOLD]) end_transfer();
      end
      pending_replies.push_back('{rb: m_last, ctrl: m_ctrl, md: m_chg});
   endtask

   function automatic int pick_gap();
      if (cycles[11:10] == 2'b11) return 0;  // quiet stretch
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic send_spi(logic act, logic [15:0] v);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_value <= v;
      do @(posedge clock); while (req_stall);
      predict_spi_reply(act, v);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_save_type(logic [2:0] t);
      wait_idle();
      csr_valid <= 1'b1;
      csr_save_type <= t;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      m_type = t;
   endtask

   task automatic send_address(logic [23:0] a);
      logic [1:0] n;
      n = addr_bytes_of(m_type);
      for (int i = n - 1; i >= 0; i--) send_spi(1'b1, {8'h00, a[8*i +: 8]});
   endtask

   // reply checking
   always @(posedge clock) begin
      spi_reply_type exp_r;
      cycles <= cycles + 1;
      if (cycles > RUN_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction: rb=%h ctrl=%h md=%b",
               rsp_read_byte, rsp_control_readback, rsp_modified);
         end else begin
            exp_r = pending_replies.pop_front();
            if (exp_r.rb !== rsp_read_byte || exp_r.ctrl !== rsp_control_readback ||
                exp_r.md !== rsp_modified) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected rb=%h ctrl=%h md=%b, got rb=%h ctrl=%h md=%b",
                     exp_r.rb, exp_r.ctrl, exp_r.md,
                     rsp_read_byte, rsp_control_readback, rsp_modified);
            end
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (cycles[11:10] == 2'b10 || $urandom_range(0, 9) < 7) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b1;
         stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
      end
   end

   task automatic test_directed();
      send_spi(1'b1, 16'h00A5);           // disabled, no chip
      set_save_type(T_FL512K);
      send_spi(1'b0, 16'hFFFF);
      send_spi(1'b1, {8'h00, OP_RDID});
      send_spi(1'b1, 16'h0000);
      send_spi(1'b1, 16'hFFFF);
      send_spi(1'b1, 16'h0000);           // past the id
      send_spi(1'b0, CTL_RELEASE);
      send_spi(1'b1, {8'h00, OP_PROG});   // no latch: ignored
      send_spi(1'b1, {8'h00, OP_WREN});
      send_spi(1'b0, CTL_HOLD_ON);
      send_spi(1'b1, {8'h00, OP_PROG});
      send_address(24'h07FFFF);
      send_spi(1'b1, 16'h005A);
      send_spi(1'b1, 16'h00C3);           // wraps to zero
      send_spi(1'b0, CTL_RELEASE);
      send_spi(1'b0, CTL_HOLD_ON);
      send_spi(1'b1, {8'h00, OP_READ});
      send_address(24'h07FFFF);
      send_spi(1'b1, 16'h0000);
      send_spi(1'b1, 16'h0000);
      send_spi(1'b0, CTL_OFF);            // disable ends the transaction
      send_spi(1'b0, CTL_HOLD_ON);
      send_spi(1'b1, {8'h00, OP_WRSR});
      send_spi(1'b1, 16'h00FF);
      send_spi(1'b0, CTL_RELEASE);
      send_spi(1'b1, 16'h0055);           // unknown opcode
      send_spi(1'b1, {8'h00, OP_DPD});
      send_spi(1'b1, {8'h00, OP_RDP});
      set_save_type(T_FL256K);
      send_spi(1'b1, {8'h00, OP_WREN});
      send_spi(1'b0, CTL_HOLD_ON);
      send_spi(1'b1, {8'h00, OP_SE4K});
      send_address(24'h07F000);           // base beyond capacity
      send_spi(1'b1, {8'h00, OP_RDSR});
      send_spi(1'b1, 16'h0000);
      send_spi(1'b0, CTL_RELEASE);
      set_save_type(3'd1);
      send_spi(1'b0, CTL_HOLD_ON);
      send_spi(1'b1, {8'h00, OP_READH});  // high half of the small eeprom
      send_spi(1'b1, 16'h00FF);
      send_spi(1'b1, 16'h0000);
      send_spi(1'b0, CTL_RELEASE);
      send_spi(1'b1, {8'h00, OP_WREN});
      send_spi(1'b1, {8'h00, OP_CE});
      set_save_type(3'd3);
      send_spi(1'b1, {8'h00, OP_WREN});
      send_spi(1'b0, CTL_HOLD_ON);
      send_spi(1'b1, {8'h00, OP_PROGH});
      send_address(24'h001234);
      send_spi(1'b1, 16'h0077);
      send_spi(1'b0, CTL_RELEASE);
   endtask

   task automatic random_sequence();
      logic [7:0] op;
      logic [7:0] ops [15];
      logic [23:0] a;
      logic [15:0] ctl;
      int unsigned cap;
      ops = '{OP_WREN, OP_WRDI, OP_RDSR, OP_WRSR, OP_READ, OP_READH, OP_PROG, OP_PROGH,
              OP_RDID, OP_SE4K, OP_SE64K, OP_PE, OP_CE, OP_DPD, OP_RDP};
      cap = capacity_of(m_type);
      op = ops[$urandom_range(0, 14)];
      if ($urandom_range(0, 19) == 0) op = 8'($urandom);
      // keep long erases rare
      if (op == OP_CE && cap > 65536) op = OP_PE;
      if (op == OP_SE64K && $urandom_range(0, 9) != 0) op = OP_SE4K;
      ctl = CTL_HOLD_ON | (16'($urandom) & 16'h6003);
      if (op inside {OP_PROG, OP_PROGH, OP_SE4K, OP_SE64K, OP_PE, OP_CE} &&
          $urandom_range(0, 9) < 8) begin
         send_spi(1'b0, ctl);
         send_spi(1'b1, {8'h00, OP_WREN});
         send_spi(1'b0, ctl & ~16'h0040);
      end
      send_spi(1'b0, ctl);
      send_spi(1'b1, {8'($urandom), op});
      if (op inside {OP_READ, OP_READH, OP_PROG, OP_PROGH, OP_SE4K, OP_SE64K, OP_PE}) begin
         a = ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1023));
         send_address(a);
      end
      if (!(op inside {OP_SE4K, OP_SE64K, OP_PE, OP_CE}))
         repeat ($urandom_range(0, 6)) send_spi(1'b1, 16'($urandom));
      send_spi(1'b0, ($urandom_range(0, 5) == 0) ? CTL_OFF : (ctl & ~16'h0040));
   endtask

   task automatic test_random();
      logic [2:0] plan [8];
      int step;
      plan = '{T_FL512K, 3'd1, 3'd3, T_FRAM, T_EE8K, T_FL256K, T_NONE, T_ALIAS};
      step = 0;
      while (items_sent < ITEM_GOAL) begin
         if (items_sent >= 70 * (step + 1)) begin
            set_save_type(step < 8 ? plan[step] : 3'($urandom_range(1, 6)));
            step++;
         end
         if ($urandom_range(0, 99) < 85) random_sequence();
         else send_spi(1'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      m_type = '0; m_ctrl = '0; m_wel = 1'b0; m_prot = '0; m_last = '0; m_chg = 1'b0;
      end_transfer();
      for (int i = 0; i < MEM_SIZE; i++) m_mem[i] = 8'hFF;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      set_save_type(T_FL512K);  // top of the range once more
      wait_idle();
      if (mismatches == 0 && pending_replies.size() == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire
